// ===== hw/rtl/dsc_pkg.sv =====
// ============================================================================
// dsc_pkg - shared definitions for the dictionary spell checker
// Constants, character codes, controller/datapath command and status types.
// ============================================================================
package dsc_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DICT_BYTES_DEF = 4096;
    localparam int MAX_WORD_DEF   = 49;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int CH_W   = 8;
    localparam int ML_W   = 6;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DICT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ART   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register map
    localparam logic [APB_AW-1:0] ADDR_MIN_LEN = 3'd0;
    localparam logic [ML_W-1:0]   MIN_LEN_RST  = 6'd2;

    // Character codes
    localparam logic [CH_W-1:0] CH_NL   = 8'h0A;
    localparam logic [CH_W-1:0] CH_UA   = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA   = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ   = 8'h7A;
    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CASE_OF = 8'h20;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic            dict_wr;
        logic            dict_clr;
        logic            letter_wr;
        logic            word_clr;
        logic            scan_start;
        logic            scan_issue;
        logic            emit_start;
        logic            emit_rd;
        logic            emit_ld;
        logic [CH_W-1:0] ch;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic word_empty;
        logic word_ovf;
        logic word_short;
        logic iss_done;
        logic scan_done;
        logic found;
        logic emit_last;
        logic out_free;
    } t_dp_status;

    function automatic logic is_upper(input logic [CH_W-1:0] c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        return is_upper(c) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic logic [CH_W-1:0] to_lower(input logic [CH_W-1:0] c);
        return is_upper(c) ? (c + CASE_OF) : c;
    endfunction

endpackage

// ===== hw/rtl/dsc_if.sv =====
// ============================================================================
// dsc_if - request channels of the dictionary spell checker
// Byte input channel and letter output channel, valid/ready handshake.
// ============================================================================

// Input channel: op-tagged bytes
interface dsc_in_if;
    logic                      valid;
    logic                      ready;
    logic [dsc_pkg::OP_W-1:0]  op;
    logic [dsc_pkg::CH_W-1:0]  char_in;

    modport source (output valid, output op, output char_in, input ready);
    modport sink   (input valid, input op, input char_in, output ready);
endinterface

// Output channel: letters of words missing from the dictionary or cut short
interface dsc_out_if;
    logic                      valid;
    logic                      ready;
    logic [dsc_pkg::CH_W-1:0]  letter_out;
    logic                      is_last;
    logic                      was_truncated;

    modport source (output valid, output letter_out, output is_last,
                    output was_truncated, input ready);
    modport sink   (input valid, input letter_out, input is_last,
                    input was_truncated, output ready);
endinterface

// ===== hw/rtl/dsc_ctrl.sv =====
// ============================================================================
// dsc_ctrl - controller of the dictionary spell checker
// Decodes incoming requests and sequences dictionary scan and letter output.
// ============================================================================
module dsc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [dsc_pkg::OP_W-1:0]  i_op,
    input  logic [dsc_pkg::CH_W-1:0]  i_char,
    input  dsc_pkg::t_dp_status       i_status,
    output logic                      o_in_ready,
    output dsc_pkg::t_dp_cmd          o_cmd
);

    dsc_pkg::t_state r_state;
    dsc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.ch   = i_char;
        o_in_ready = (r_state == dsc_pkg::S_IDLE);
        unique case (r_state)
            dsc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        dsc_pkg::OP_DICT: begin
                            o_cmd.dict_wr = 1'b1;
                        end
                        dsc_pkg::OP_CLEAR: begin
                            o_cmd.dict_clr = 1'b1;
                            o_cmd.word_clr = 1'b1;
                        end
                        dsc_pkg::OP_ART: begin
                            if (dsc_pkg::is_letter(i_char)) begin
                                o_cmd.letter_wr = 1'b1;
                            end else if (i_status.word_empty) begin
                                o_cmd.word_clr = 1'b1;
                            end else if (i_status.word_ovf) begin
                                // cut word: reported without a lookup
                                o_cmd.emit_start = 1'b1;
                                n_state          = dsc_pkg::S_EMIT_RD;
                            end else if (i_status.word_short) begin
                                o_cmd.word_clr = 1'b1;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = dsc_pkg::S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dsc_pkg::S_SCAN: begin
                o_cmd.scan_issue = !i_status.iss_done;
                if (i_status.scan_done) begin
                    if (i_status.found) begin
                        o_cmd.word_clr = 1'b1;
                        n_state        = dsc_pkg::S_IDLE;
                    end else begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = dsc_pkg::S_EMIT_RD;
                    end
                end
            end
            dsc_pkg::S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = dsc_pkg::S_EMIT_LD;
            end
            dsc_pkg::S_EMIT_LD: begin
                // hold the buffer address until the output register frees
                o_cmd.emit_rd = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.word_clr = 1'b1;
                        n_state        = dsc_pkg::S_IDLE;
                    end else begin
                        n_state = dsc_pkg::S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = dsc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dsc_datapath.sv =====
// ============================================================================
// dsc_datapath - datapath of the dictionary spell checker
// Dictionary store, word buffer, three-stage compare pipeline, output register.
// ============================================================================
module dsc_datapath #(
    parameter int DICT_BYTES = dsc_pkg::DICT_BYTES_DEF,
    parameter int MAX_WORD   = dsc_pkg::MAX_WORD_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dsc_pkg::t_dp_cmd          i_cmd,
    input  logic [dsc_pkg::ML_W-1:0]  i_min_len,
    input  logic                      i_out_ready,
    output dsc_pkg::t_dp_status       o_status,
    output logic                      o_out_valid,
    output logic [dsc_pkg::CH_W-1:0]  o_letter,
    output logic                      o_is_last,
    output logic                      o_truncated
);

    localparam int AW    = $clog2(DICT_BYTES);
    localparam int PW    = $clog2(DICT_BYTES + 1);
    localparam int WBAW  = $clog2(MAX_WORD);
    localparam int WLW   = $clog2(MAX_WORD + 1);
    localparam int KW    = $clog2(MAX_WORD + 2);
    localparam int CMP_W = (WLW > dsc_pkg::ML_W) ? WLW : dsc_pkg::ML_W;

    // Storage
    logic [dsc_pkg::CH_W-1:0] r_dict [DICT_BYTES];
    logic [dsc_pkg::CH_W-1:0] r_wb   [MAX_WORD];
    logic [dsc_pkg::CH_W-1:0] r_dict_q;
    logic [dsc_pkg::CH_W-1:0] r_wb_q;

    logic [PW-1:0]  r_fill;
    logic [WLW-1:0] r_wlen;
    logic           r_ovf;

    // Scan state
    logic [PW-1:0]  r_pos;
    logic           r_iss_done;
    logic [KW-1:0]  r_k;
    logic           r_mis;
    logic           r_found;
    logic           r_b_vld;
    logic           r_b_end;
    logic           r_c_vld;
    logic           r_c_end;
    logic           r_c_eoe;
    logic [KW-1:0]  r_c_k;
    logic [dsc_pkg::CH_W-1:0] r_c_byte;

    // Output side
    logic [WLW-1:0] r_ek;
    logic           r_ov;
    logic [dsc_pkg::CH_W-1:0] r_letter;
    logic           r_last;
    logic           r_trunc;

    logic                 dict_we;
    logic                 b_eoe;
    logic                 entry_hit;
    logic [WBAW-1:0]      scan_addr;
    logic [WBAW-1:0]      wb_raddr;
    logic                 out_free;
    logic                 emit_last;

    assign dict_we = i_cmd.dict_wr && (r_fill != PW'(DICT_BYTES))
                     && (i_cmd.ch != dsc_pkg::CH_NUL);
    assign b_eoe   = r_b_end || (r_dict_q == dsc_pkg::CH_NL);

    // Entry ends with its offset equal to the word length and no mismatch
    assign entry_hit = r_c_vld && r_c_eoe && !r_mis && (r_c_k == KW'(r_wlen));

    assign scan_addr = (r_k < KW'(r_wlen)) ? r_k[WBAW-1:0] : '0;
    assign wb_raddr  = i_cmd.emit_rd ? r_ek[WBAW-1:0] : scan_addr;
    assign out_free  = !r_ov || i_out_ready;
    assign emit_last = (r_ek == (r_wlen - WLW'(1)));

    // Dictionary store
    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict[r_fill[AW-1:0]] <= i_cmd.ch;
        end
        r_dict_q <= r_dict[r_pos[AW-1:0]];
    end

    // Word buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.letter_wr && (r_wlen != WLW'(MAX_WORD))) begin
            r_wb[r_wlen[WBAW-1:0]] <= dsc_pkg::to_lower(i_cmd.ch);
        end
        r_wb_q <= r_wb[wb_raddr];
    end

    // Fill count, word length and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wlen <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.dict_clr) begin
                r_fill <= '0;
            end else if (dict_we) begin
                r_fill <= r_fill + PW'(1);
            end
            if (i_cmd.word_clr) begin
                r_wlen <= '0;
                r_ovf  <= 1'b0;
            end else if (i_cmd.letter_wr) begin
                if (r_wlen != WLW'(MAX_WORD)) begin
                    r_wlen <= r_wlen + WLW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // Scan pipeline: issue read, classify byte and fetch letter, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_start) begin
            r_pos      <= '0;
            r_iss_done <= 1'b0;
            r_k        <= '0;
            r_mis      <= 1'b0;
            r_found    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_b_end    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_c_end    <= 1'b0;
            r_c_eoe    <= 1'b0;
            r_c_k      <= '0;
        end else begin
            // stage A: dictionary address
            r_b_vld <= i_cmd.scan_issue;
            if (i_cmd.scan_issue) begin
                r_b_end    <= (r_pos == r_fill);
                r_iss_done <= (r_pos == r_fill);
                r_pos      <= r_pos + PW'(1);
            end
            // stage B: entry boundary and offset within entry
            r_c_vld <= r_b_vld;
            r_c_end <= r_b_vld && r_b_end;
            r_c_eoe <= b_eoe;
            r_c_k   <= r_k;
            if (r_b_vld) begin
                if (b_eoe) begin
                    r_k <= '0;
                end else if (r_k != KW'(MAX_WORD + 1)) begin
                    r_k <= r_k + KW'(1);
                end
            end
            // stage C: byte against buffered letter
            if (r_c_vld) begin
                if (r_c_eoe) begin
                    r_mis <= 1'b0;
                    if (entry_hit) begin
                        r_found <= 1'b1;
                    end
                end else if ((r_c_k >= KW'(r_wlen)) || (r_c_byte != r_wb_q)) begin
                    r_mis <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_byte <= dsc_pkg::to_lower(r_dict_q);
    end

    // Letter index for output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_start) begin
            r_ek <= '0;
        end else if (i_cmd.emit_ld) begin
            r_ek <= r_ek + WLW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_letter <= r_wb_q;
            r_last   <= emit_last;
            r_trunc  <= r_ovf;
        end
    end

    // Status
    always_comb begin
        o_status.word_empty = (r_wlen == '0);
        o_status.word_ovf   = r_ovf;
        o_status.word_short = (CMP_W'(r_wlen) < CMP_W'(i_min_len));
        o_status.iss_done   = r_iss_done;
        o_status.scan_done  = r_c_vld && r_c_end;
        o_status.found      = r_found || entry_hit;
        o_status.emit_last  = emit_last;
        o_status.out_free   = out_free;
    end

    assign o_out_valid = r_ov;
    assign o_letter    = r_letter;
    assign o_is_last   = r_last;
    assign o_truncated = r_trunc;

endmodule

// ===== hw/rtl/dictionary_spell_checker_top.sv =====
// ============================================================================
// dictionary_spell_checker_top - dictionary spell checker
// Stores a newline-separated dictionary and reports article words not in it or cut short.
// ============================================================================
//
//  channel   direction  handshake        payload
//  i_in      in         valid / ready    op, char_in
//  o_out     out        valid / ready    letter_out, is_last, was_truncated
//  apb       in         psel / penable   paddr, pwdata -> prdata
//
//  Dictionary, clear and letter requests are accepted only in the idle state.
//  A word end starts a scan of the store unless the word is empty, cut or
//  below the minimum length; the scan reads one stored byte per cycle through
//  the single dictionary read port. Each letter of a reported word takes a word
//  buffer read, then an output register load; output stalls hold the controller in place.
//  Reset (synchronous, active low) empties dictionary and word at once.
//
module dictionary_spell_checker_top #(
    parameter int DICT_BYTES = dsc_pkg::DICT_BYTES_DEF,
    parameter int MAX_WORD   = dsc_pkg::MAX_WORD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dsc_in_if.sink                       i_in,
    dsc_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsc_pkg::APB_AW-1:0]   paddr,
    input  logic [dsc_pkg::APB_DW-1:0]   pwdata,
    output logic [dsc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    logic [dsc_pkg::ML_W-1:0] r_min_len;
    dsc_pkg::t_dp_cmd         cmd;
    dsc_pkg::t_dp_status      status;
    logic                     in_ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= dsc_pkg::MIN_LEN_RST;
        end else if (psel && penable && pwrite && (paddr == dsc_pkg::ADDR_MIN_LEN)) begin
            r_min_len <= pwdata[dsc_pkg::ML_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == dsc_pkg::ADDR_MIN_LEN) ? dsc_pkg::APB_DW'(r_min_len) : '0;

    // Controller
    dsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .i_char     (i_in.char_in),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Datapath
    dsc_datapath #(
        .DICT_BYTES (DICT_BYTES),
        .MAX_WORD   (MAX_WORD)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_min_len   (r_min_len),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_letter    (o_out.letter_out),
        .o_is_last   (o_out.is_last),
        .o_truncated (o_out.was_truncated)
    );

endmodule
